// ===== hdl/rsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg: shared types for the RLE scanline decoder
// Parser modes, result kinds and the run descriptor that flows from the
// front parser through the queue to the output stage.
// ----------------------------------------------------------------------------
package rsd_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CTRL    = 2'd1,
    MODE_LITERAL = 2'd2,
    MODE_REPEAT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RUN     = 2'd0,
    KIND_EOL     = 2'd1,
    KIND_OVERRUN = 2'd2
  } kind_t;

  localparam int unsigned COL_W   = 9;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  localparam logic [7:0] LITERAL_FLAG = 8'h80;
  localparam logic [7:0] COUNT_MASK   = 8'h7f;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       pixel_value;
    logic [7:0]       row;
    logic [1:0]       channel;
    logic [7:0]       start_column;
    logic [CNT_W-1:0] run_length;
  } result_t;

endpackage

// ===== hdl/rsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_front: control-byte parser
// Takes one compressed byte per cycle while the queue is not full, tracks mode,
// count and column, and pushes at most one run descriptor per byte into the queue.
// ----------------------------------------------------------------------------
module rsd_front #(
  parameter int unsigned LINE_WIDTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_line_start,
  input  logic [7:0]          in_row,
  input  logic [1:0]          in_channel,
  input  logic                q_full,
  output logic                push,
  output rsd_pkg::result_t    push_res
);

  rsd_pkg::mode_t                  mode_r, mode_nxt, mode_eff;
  logic [rsd_pkg::CNT_W-1:0]       remaining_r, remaining_nxt, rem_dec;
  logic [rsd_pkg::COL_W-1:0]       column_r, column_nxt, col_eff;
  logic [7:0]                      cur_row_r, cur_row_nxt;
  logic [1:0]                      cur_channel_r, cur_channel_nxt;
  logic [rsd_pkg::CNT_W-1:0]       ctrl_count;
  logic [rsd_pkg::COL_W:0]         lit_end, rep_end;
  logic [7:0]                      start_sat;
  logic                            accept;
  logic                            res_valid;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // A line start forces the byte to be read as a control byte
  assign mode_eff        = in_line_start ? rsd_pkg::MODE_CTRL : mode_r;
  assign col_eff         = in_line_start ? '0 : column_r;
  assign cur_row_nxt     = in_line_start ? in_row : cur_row_r;
  assign cur_channel_nxt = in_line_start ? in_channel : cur_channel_r;

  assign ctrl_count = rsd_pkg::CNT_W'(in_data_byte & rsd_pkg::COUNT_MASK);
  assign rem_dec    = remaining_r - rsd_pkg::CNT_W'(1);
  assign lit_end    = {1'b0, col_eff} + (rsd_pkg::COL_W+1)'(1);
  assign rep_end    = {1'b0, col_eff} + (rsd_pkg::COL_W+1)'(remaining_r);
  assign start_sat  = col_eff[rsd_pkg::COL_W-1] ? 8'hff : col_eff[7:0];

  // next mode
  always_comb begin
    mode_nxt = mode_eff;
    unique case (mode_eff)
      rsd_pkg::MODE_IDLE: mode_nxt = rsd_pkg::MODE_IDLE;
      rsd_pkg::MODE_CTRL: begin
        if (ctrl_count == '0) begin
          mode_nxt = rsd_pkg::MODE_IDLE;
        end else if ((in_data_byte & rsd_pkg::LITERAL_FLAG) != 8'h00) begin
          mode_nxt = rsd_pkg::MODE_LITERAL;
        end else begin
          mode_nxt = rsd_pkg::MODE_REPEAT;
        end
      end
      rsd_pkg::MODE_LITERAL: begin
        if (rem_dec == '0) begin
          mode_nxt = rsd_pkg::MODE_CTRL;
        end
      end
      rsd_pkg::MODE_REPEAT: mode_nxt = rsd_pkg::MODE_CTRL;
      default: mode_nxt = rsd_pkg::MODE_IDLE;
    endcase
  end

  // counters and result
  always_comb begin
    remaining_nxt         = remaining_r;
    column_nxt            = col_eff;
    res_valid             = 1'b0;
    push_res.kind         = rsd_pkg::KIND_RUN;
    push_res.pixel_value  = in_data_byte;
    push_res.row          = cur_row_nxt;
    push_res.channel      = cur_channel_nxt;
    push_res.start_column = start_sat;
    push_res.run_length   = '0;
    unique case (mode_eff)
      rsd_pkg::MODE_IDLE: begin
      end
      rsd_pkg::MODE_CTRL: begin
        remaining_nxt = ctrl_count;
        if (ctrl_count == '0) begin
          res_valid             = 1'b1;
          push_res.kind         = rsd_pkg::KIND_EOL;
          push_res.pixel_value  = '0;
          push_res.start_column = '0;
        end
      end
      rsd_pkg::MODE_LITERAL: begin
        remaining_nxt = rem_dec;
        res_valid     = 1'b1;
        if (lit_end > (rsd_pkg::COL_W+1)'(LINE_WIDTH)) begin
          push_res.kind = rsd_pkg::KIND_OVERRUN;
        end else begin
          push_res.run_length = rsd_pkg::CNT_W'(1);
          column_nxt          = lit_end[rsd_pkg::COL_W-1:0];
        end
      end
      rsd_pkg::MODE_REPEAT: begin
        remaining_nxt = '0;
        res_valid     = 1'b1;
        if (rep_end > (rsd_pkg::COL_W+1)'(LINE_WIDTH)) begin
          push_res.kind = rsd_pkg::KIND_OVERRUN;
        end else begin
          push_res.run_length = remaining_r;
          column_nxt          = rep_end[rsd_pkg::COL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign push = accept && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= rsd_pkg::MODE_IDLE;
      remaining_r   <= '0;
      column_r      <= '0;
      cur_row_r     <= '0;
      cur_channel_r <= '0;
    end else if (accept) begin
      mode_r        <= mode_nxt;
      remaining_r   <= remaining_nxt;
      column_r      <= column_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_channel_r <= cur_channel_nxt;
    end
  end

endmodule

// ===== hdl/rsd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_queue: two-entry descriptor queue
// Decouples the parser from the output stage so each side stalls alone.
// ----------------------------------------------------------------------------
module rsd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rsd_pkg::result_t push_res,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output rsd_pkg::result_t q_res
);

  rsd_pkg::result_t              mem_r [rsd_pkg::QDEPTH];
  logic [rsd_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [rsd_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                          do_pop;

  assign full    = (count_r == rsd_pkg::QCNT_W'(rsd_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_res   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + rsd_pkg::QCNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - rsd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + rsd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + rsd_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// ===== hdl/rsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_back: result output register
// Pulls descriptors from the queue and holds each beat until taken.
// ----------------------------------------------------------------------------
module rsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  rsd_pkg::result_t q_res,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output rsd_pkg::result_t out_res
);

  logic             out_valid_r, out_valid_nxt;
  rsd_pkg::result_t out_res_r;

  // Load whenever the register is empty or its beat leaves this cycle
  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res_r <= q_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== hdl/rle_scanline_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_scanline_decoder_core: 8-bit RLE scanline decoder
// Input channel: one compressed byte per beat (in_data_byte), with
// in_line_start marking the first control byte of a line and in_row /
// in_channel latched on that beat. A beat moves when in_valid is high and
// in_stall is low.
// Output channel: one run descriptor per beat (kind, value, row, channel,
// start column, length); a beat moves when out_valid is high and out_stall
// is low. Control bytes yield nothing except a zero count (end of line);
// runs past LINE_WIDTH come out as overrun and do not advance the column.
// Throughput: one byte per cycle while the queue is not full (in_stall low).
// Path: a result is written into a two-entry queue when its byte is taken and
// is then loaded into the output register, from which it is presented.
// Receiver stall: the output register holds, the queue fills, and in_stall
// rises once both queue entries are in use.
// Reset (synchronous, rst_n low): parser idle, column and counts cleared,
// queue and output register empty.
// ----------------------------------------------------------------------------
module rle_scanline_decoder_core #(
  parameter int unsigned LINE_WIDTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_start,
  input  logic [7:0] in_row,
  input  logic [1:0] in_channel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_pixel_value,
  output logic [7:0] out_row,
  output logic [1:0] out_channel,
  output logic [7:0] out_start_column,
  output logic [6:0] out_run_length
);

  logic             push, q_full, q_valid, pop;
  rsd_pkg::result_t push_res, q_res, out_res;

  rsd_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_line_start(in_line_start),
    .in_row       (in_row),
    .in_channel   (in_channel),
    .q_full       (q_full),
    .push         (push),
    .push_res     (push_res)
  );

  rsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_res(push_res),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_res   (q_res)
  );

  rsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_res    (q_res),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_pixel_value  = out_res.pixel_value;
  assign out_row          = out_res.row;
  assign out_channel      = out_res.channel;
  assign out_start_column = out_res.start_column;
  assign out_run_length   = out_res.run_length;

endmodule

// ===== tb/rle_scanline_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_scanline_decoder_core_tb: self-checking bench for the RLE scanline decoder
// Directed scanlines first: ignored idle bytes, line ends, literal and repeat
// packets, overruns at the right edge, restarts mid-packet and channel 3.
// Then random scanlines, mostly well formed with some truncated and some noise.
// A behavioural decoder predicts each run descriptor as a byte is taken; every
// descriptor that leaves the block is compared field by field, in order.
// Both sides insert random gaps.
// ----------------------------------------------------------------------------
module rle_scanline_decoder_core_tb;

  localparam int LINE_WIDTH   = 256;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_line_start = 1'b0;
  logic [7:0] in_row = 8'h00;
  logic [1:0] in_channel = 2'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_pixel_value;
  logic [7:0] out_row;
  logic [1:0] out_channel;
  logic [7:0] out_start_column;
  logic [6:0] out_run_length;

  rle_scanline_decoder_core #(
    .LINE_WIDTH(LINE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_line_start(in_line_start),
    .in_row(in_row),
    .in_channel(in_channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_pixel_value(out_pixel_value),
    .out_row(out_row),
    .out_channel(out_channel),
    .out_start_column(out_start_column),
    .out_run_length(out_run_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoder state mirrored by the bench
  rsd_pkg::mode_t dec_mode = rsd_pkg::MODE_IDLE;
  logic [6:0]     dec_left = '0;
  logic [8:0]     dec_col = '0;
  logic [7:0]     dec_row = '0;
  logic [1:0]     dec_chan = '0;

  rsd_pkg::result_t pending_descs[$];

  int errors = 0;
  int cycles = 0;
  int n_bytes = 0;
  int n_lines = 0;
  int line_bytes = 0;
  int n_runs = 0;
  int n_eols = 0;
  int n_overruns = 0;
  int gap_level = 1;
  int stall_level = 1;
  int stall_left = 0;

  function automatic rsd_pkg::result_t make_desc(rsd_pkg::kind_t k, logic [7:0] v,
                                                 logic [8:0] start, logic [6:0] len);
    rsd_pkg::result_t d;
    d.kind         = k;
    d.pixel_value  = v;
    d.row          = dec_row;
    d.channel      = dec_chan;
    d.start_column = (start > 9'd255) ? 8'hff : start[7:0];
    d.run_length   = len;
    return d;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic ls, input logic [7:0] row,
                             input logic [1:0] ch);
    logic [6:0] cnt;
    if (ls) begin
      dec_row  = row;
      dec_chan = ch;
      dec_col  = '0;
      dec_mode = rsd_pkg::MODE_CTRL;
    end
    case (dec_mode)
      rsd_pkg::MODE_CTRL: begin
        cnt = b[6:0];
        if (cnt == 0) begin
          dec_mode = rsd_pkg::MODE_IDLE;
          dec_left = '0;
          pending_descs.push_back(make_desc(rsd_pkg::KIND_EOL, 8'h00, 9'd0, 7'd0));
        end else begin
          dec_left = cnt;
          dec_mode = (b & rsd_pkg::LITERAL_FLAG) != 0 ? rsd_pkg::MODE_LITERAL
                                                      : rsd_pkg::MODE_REPEAT;
        end
      end
      rsd_pkg::MODE_LITERAL: begin
        dec_left = dec_left - 7'd1;
        if (dec_left == 0) dec_mode = rsd_pkg::MODE_CTRL;
        if (int'(dec_col) + 1 > LINE_WIDTH) begin
          pending_descs.push_back(make_desc(rsd_pkg::KIND_OVERRUN, b, dec_col, 7'd0));
        end else begin
          pending_descs.push_back(make_desc(rsd_pkg::KIND_RUN, b, dec_col, 7'd1));
          dec_col = dec_col + 9'd1;
        end
      end
      rsd_pkg::MODE_REPEAT: begin
        cnt = dec_left;
        dec_left = '0;
        dec_mode = rsd_pkg::MODE_CTRL;
        if (int'(dec_col) + int'(cnt) > LINE_WIDTH) begin
          pending_descs.push_back(make_desc(rsd_pkg::KIND_OVERRUN, b, dec_col, 7'd0));
        end else begin
          pending_descs.push_back(make_desc(rsd_pkg::KIND_RUN, b, dec_col, cnt));
          dec_col = dec_col + 9'(cnt);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (gap_level == 0) return 0;
    if (gap_level == 1) return (r < 80) ? 0 : $urandom_range(1, 3);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 30);
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_level == 1 && $urandom_range(99) < 15) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else if (stall_level == 2 && $urandom_range(99) < 30) begin
      stall_left <= ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(9, 39);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each descriptor beat with the oldest prediction
  always @(posedge clk) begin
    rsd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_descs.size() == 0) begin
        report_mismatch($sformatf("unexpected descriptor kind %0d value %0d col %0d",
                                  out_kind, out_pixel_value, out_start_column));
      end else begin
        want = pending_descs.pop_front();
        check_field("kind", out_kind, want.kind);
        check_field("pixel_value", out_pixel_value, want.pixel_value);
        check_field("row", out_row, want.row);
        check_field("channel", out_channel, want.channel);
        check_field("start_column", out_start_column, want.start_column);
        check_field("run_length", out_run_length, want.run_length);
        case (want.kind)
          rsd_pkg::KIND_RUN: n_runs++;
          rsd_pkg::KIND_EOL: n_eols++;
          default:           n_overruns++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d descriptors outstanding",
               cycles, pending_descs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ls, input logic [7:0] row,
                           input logic [1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_line_start <= ls;
    in_row        <= row;
    in_channel    <= ch;
    do @(posedge clk); while (in_stall);
    decode_byte(b, ls, row, ch);
    n_bytes++;
  endtask

  task automatic open_line(input logic [7:0] ctrl, input logic [7:0] row,
                           input logic [1:0] ch);
    send_byte(ctrl, 1'b1, row, ch);
    n_lines++;
  endtask

  // Row and channel are don't-care off line start: scramble them
  task automatic line_byte(input logic [7:0] b);
    send_byte(b, 1'b0, 8'($urandom), 2'($urandom));
  endtask

  // Control byte inside an open line
  task automatic open_line_continue(input logic [7:0] ctrl);
    line_byte(ctrl);
  endtask

  // Hold the sender until every predicted descriptor has come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_idle_bytes();
    line_byte(8'h00);
    line_byte(8'hff);
  endtask

  task automatic test_line_end();
    open_line(8'h00, 8'hff, 2'd2);
    open_line(rsd_pkg::LITERAL_FLAG, 8'h00, 2'd1);
  endtask

  task automatic test_literal_and_repeat();
    open_line(rsd_pkg::LITERAL_FLAG | 8'h03, 8'h5a, 2'd0);
    line_byte(8'h00);
    line_byte(8'hff);
    line_byte(8'h5a);
    open_line_continue(rsd_pkg::COUNT_MASK);
    line_byte(8'ha5);
    line_byte(8'h00);
  endtask

  task automatic test_overrun();
    open_line(rsd_pkg::COUNT_MASK, 8'h10, 2'd1);
    line_byte(8'h11);
    line_byte(rsd_pkg::COUNT_MASK);
    line_byte(8'h22);
    // column 254: three would pass the edge, two fit exactly
    line_byte(8'h03);
    line_byte(8'h33);
    line_byte(8'h02);
    line_byte(8'h44);
    // line full: a literal byte overruns with the column saturated
    line_byte(rsd_pkg::LITERAL_FLAG | 8'h01);
    line_byte(8'h55);
    line_byte(8'h00);
  endtask

  task automatic test_line_restart();
    open_line(rsd_pkg::LITERAL_FLAG | 8'h05, 8'h77, 2'd3);
    line_byte(8'h99);
    open_line(8'h02, 8'h78, 2'd3);
    open_line(8'h00, 8'h79, 2'd2);
  endtask

  task automatic random_line();
    logic [7:0] stream[$];
    logic [7:0] row;
    logic [1:0] ch;
    int npk, sel, cnt, cut;
    npk = $urandom_range(1, 14);
    repeat (npk) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        cnt = ($urandom_range(99) < 3) ? $urandom_range(9, 127) : $urandom_range(1, 6);
        stream.push_back(rsd_pkg::LITERAL_FLAG | 8'(cnt));
        repeat (cnt) stream.push_back(8'($urandom));
      end else if (sel < 95) begin
        cnt = ($urandom_range(99) < 20) ? $urandom_range(41, 127) : $urandom_range(1, 40);
        stream.push_back(8'(cnt));
        stream.push_back(8'($urandom));
      end else begin
        stream.push_back(8'($urandom));
      end
    end
    stream.push_back($urandom_range(1) ? rsd_pkg::LITERAL_FLAG : 8'h00);
    // truncate now and then; the next line start must recover
    if ($urandom_range(99) < 10) begin
      cut = $urandom_range(1, stream.size() - 1);
      stream = stream[0:cut-1];
    end
    if ($urandom_range(99) < 6)
      repeat ($urandom_range(1, 3)) line_byte(8'($urandom));
    row = 8'($urandom);
    ch  = 2'($urandom_range(2));
    open_line(stream[0], row, ch);
    for (int i = 1; i < stream.size(); i++) line_byte(stream[i]);
    line_bytes += stream.size();
  endtask

  task automatic test_random_lines();
    bit drained;
    drained = 1'b0;
    gap_level = 0;
    stall_level = 0;
    while (line_bytes < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        gap_level = $urandom_range(2);
        stall_level = $urandom_range(2);
      end
      if (!drained && line_bytes > RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained = 1'b1;
      end
      random_line();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_bytes();
    test_line_end();
    test_literal_and_repeat();
    test_overrun();
    test_line_restart();
    test_random_lines();

    wait_for_drain();

    $display("Covered %0d bytes over %0d scanlines in %0d cycles", n_bytes, n_lines, cycles);
    $display("Descriptors checked: %0d runs, %0d line ends, %0d overruns; %0d mismatches",
             n_runs, n_eols, n_overruns, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rsd_pkg.sv
hdl/rsd_front.sv
hdl/rsd_queue.sv
hdl/rsd_back.sv
hdl/rle_scanline_decoder_core.sv
tb/rle_scanline_decoder_core_tb.sv
